[hdl/aavr_pkg.sv]
`timescale 1ns / 1ps

package aavr_pkg;

  // Stream and register geometry
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_STAGES = 16;
  localparam int REG_W       = 16;
  localparam int NREG        = 4;
  localparam int CFG_IDX_W   = 8;

  localparam int IN_DATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_BITS + 7) / 8) * 8;

  // CORDIC: Q2.30 working values with headroom for gain and negation
  localparam int ATAN_LEN = 24;
  localparam int STEPS    = (TRIG_STAGES < ATAN_LEN) ? TRIG_STAGES : ATAN_LEN;
  localparam int IDX_W    = $clog2(ATAN_LEN);
  localparam int TRIG_W   = 34;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Matrix entries, Q.28
  localparam int ENT_W = 32;
  localparam int FRAC  = 28;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ANGLE = 8'd3;

  typedef logic signed [REG_W-1:0]       axc_t;
  typedef axc_t [2:0]                    axis_t;
  typedef logic signed [ENT_W-1:0]       ent_t;
  typedef ent_t [2:0]                    row_t;
  typedef row_t [2:0]                    mat_t;
  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef smp_t [2:0]                    vec_t;

  typedef struct packed {
    logic valid;
    mat_t m;
  } mat_out_t;

  // Arctangent of 2^-i, one turn = 2^32
  function automatic logic signed [31:0] atan_val(input logic [IDX_W-1:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0:    r = 32'sd536870912;
      5'd1:    r = 32'sd316933406;
      5'd2:    r = 32'sd167458907;
      5'd3:    r = 32'sd85004756;
      5'd4:    r = 32'sd42667331;
      5'd5:    r = 32'sd21354465;
      5'd6:    r = 32'sd10679838;
      5'd7:    r = 32'sd5340245;
      5'd8:    r = 32'sd2670163;
      5'd9:    r = 32'sd1335087;
      5'd10:   r = 32'sd667544;
      5'd11:   r = 32'sd333772;
      5'd12:   r = 32'sd166886;
      5'd13:   r = 32'sd83443;
      5'd14:   r = 32'sd41722;
      5'd15:   r = 32'sd20861;
      5'd16:   r = 32'sd10430;
      5'd17:   r = 32'sd5215;
      5'd18:   r = 32'sd2608;
      5'd19:   r = 32'sd1304;
      5'd20:   r = 32'sd652;
      5'd21:   r = 32'sd326;
      5'd22:   r = 32'sd163;
      5'd23:   r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/axis_angle_vector_rotation.sv]
`timescale 1ns / 1ps

// Axis-angle vector rotator.
// Configure the unit axis (Q1.15 x, y, z) and the turn angle (65536 = one
// turn) over the cfg channel; cfg_ready is always high. Each register write
// starts a rebuild of the 3x3 rotation matrix: a 16-step CORDIC for sine and
// cosine, then the nine entries one after another on a shared multiplier.
// A rebuild runs the CORDIC steps, then the three cross-product terms, then
// each entry through the AA, LO, HI, RND and WR states; s_axis_tready stays
// low until it finishes. Reset loads the default axis (+z) and angle zero and
// runs the same rebuild.
// Vectors enter on s_axis (x, y, z, 16 bits each) and leave on m_axis
// (x, y, z, 17 bits each, saturated). Three lanes, one per matrix row, work
// on each beat in parallel; a merge register packs their results.
// Each beat passes the lane product register and then the merge register;
// one beat is taken every cycle while the matrix is valid and nothing stalls.
// When the receiver stalls, the output register holds its beat and the lane
// stage behind it still takes one more beat before s_axis_tready drops.
module axis_angle_vector_rotation import aavr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // config write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  // input vectors
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // vec_x, vec_y, vec_z
  // rotated vectors
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // out_x, out_y, out_z, zero pad
);

  axis_t                      axis;
  logic [REG_W-1:0]           turn_angle;
  logic                       wr_hit;
  mat_out_t                   mo;
  vec_t                       vec;
  logic signed [OUT_BITS-1:0] res [3];
  logic                       vld1, en1, en2, in_acc;
  logic [OUT_DATA_W-1:0]      out_data;

  // Register writes; an index beyond the list is dropped
  assign cfg_ready = 1'b1;
  assign wr_hit    = cfg_valid && (cfg_index inside {[REG_AXIS_X:REG_TURN_ANGLE]});

  always_ff @(posedge clk) begin
    if (rst) begin
      axis[0]    <= '0;
      axis[1]    <= '0;
      axis[2]    <= 16'sd32767;
      turn_angle <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AXIS_X:     axis[0] <= cfg_data;
        REG_AXIS_Y:     axis[1] <= cfg_data;
        REG_AXIS_Z:     axis[2] <= cfg_data;
        REG_TURN_ANGLE: turn_angle <= cfg_data;
        default: ;
      endcase
    end
  end

  aavr_mat u_mat (
    .clk   (clk),
    .rst   (rst),
    .start (wr_hit),
    .axis  (axis),
    .angle (turn_angle),
    .mo    (mo)
  );

  // Stage enables: advance a stage when the one after it moves or it is empty
  assign en2           = !m_axis_tvalid || m_axis_tready;
  assign en1           = !vld1 || en2;
  assign s_axis_tready = mo.valid && en1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign vec = s_axis_tdata[3*SAMPLE_BITS-1:0];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    aavr_lane u_lane (
      .clk  (clk),
      .load (in_acc),
      .vec  (vec),
      .row  (mo.m[g]),
      .res  (res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en1) vld1 <= in_acc;
      if (en2) m_axis_tvalid <= vld1;
    end
  end

  // Merge the three lane results into one output beat
  always_ff @(posedge clk) begin
    if (en2 && vld1) begin
      out_data <= OUT_DATA_W'({res[2], res[1], res[0]});
    end
  end

  assign m_axis_tdata = out_data;

`ifndef ASSERT_OFF
  a_rebuild_blocks: assert property (@(posedge clk) disable iff (rst)
    wr_hit |=> !s_axis_tready)
    else $error("input accepted while the matrix is being rebuilt");

  a_lane_holds: assert property (@(posedge clk) disable iff (rst)
    vld1 && m_axis_tvalid && !m_axis_tready |=> vld1)
    else $error("lane beat lost during output stall");

  a_out_from_lane: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(vld1))
    else $error("output beat without a lane beat behind it");
`endif

endmodule

[hdl/aavr_cordic.sv]
`timescale 1ns / 1ps

module aavr_cordic import aavr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [REG_W-1:0]         angle,
  output logic                     done,
  output logic signed [TRIG_W-1:0] cs,
  output logic signed [TRIG_W-1:0] sn
);

  localparam int ANG_USE = (ANGLE_BITS < REG_W) ? ANGLE_BITS : REG_W;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  logic [31:0]              phase;
  logic signed [TRIG_W-1:0] x, y, dx, dy;
  logic signed [31:0]       z, at;
  logic [IDX_W-1:0]         idx;
  logic [1:0]               quad;
  logic                     busy;

  assign phase = 32'(angle[ANG_USE-1:0]) << (32 - ANGLE_BITS);
  assign dx    = y >>> idx;
  assign dy    = x >>> idx;
  assign at    = atan_val(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        if (idx == IDX_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // One micro-rotation per cycle; direction from the sign of the residual angle
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= {2'b00, phase[29:0]};
      quad <= phase[31:30];
    end else if (busy) begin
      if (!z[31]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  always_comb begin
    case (quad)
      QUAD_I: begin
        cs = x;
        sn = y;
      end
      QUAD_II: begin
        cs = -y;
        sn = x;
      end
      QUAD_III: begin
        cs = -x;
        sn = -y;
      end
      default: begin
        cs = y;
        sn = -x;
      end
    endcase
  end

endmodule

[hdl/aavr_mat.sv]
`timescale 1ns / 1ps

module aavr_mat import aavr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  axis_t            axis,
  input  logic [REG_W-1:0] angle,
  output mat_out_t         mo
);

  localparam int ICA_W = TRIG_W + 1;
  localparam int LO_W  = 17;
  localparam int HI_W  = ICA_W - LO_W;
  localparam int PRD_W = 2 * REG_W;
  localparam int ACC_W = 68;
  localparam int SKP_W = REG_W + TRIG_W;

  localparam logic signed [ICA_W-1:0] ONE_Q30  = ICA_W'(64'sd1 <<< 30);
  localparam logic signed [ACC_W-1:0] HALF_AA  = ACC_W'(64'sd1 <<< 31);
  localparam logic signed [SKP_W-1:0] HALF_SK  = SKP_W'(64'sd1 <<< 16);
  localparam logic signed [TRIG_W-1:0] HALF_C  = TRIG_W'(2);

  typedef enum logic [9:0] {
    S_START = 10'b0000000001,
    S_TRIG  = 10'b0000000010,
    S_PREP  = 10'b0000000100,
    S_SKEW  = 10'b0000001000,
    S_AA    = 10'b0000010000,
    S_LO    = 10'b0000100000,
    S_HI    = 10'b0001000000,
    S_RND   = 10'b0010000000,
    S_WR    = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } st_t;

  st_t st;
  logic [1:0] k, ri, ci;
  logic       valid;

  logic                     tdone;
  logic signed [TRIG_W-1:0] cs, sn;

  logic signed [ICA_W-1:0]  ica;
  logic [LO_W-1:0]          ica_lo;
  logic signed [HI_W-1:0]   ica_hi;
  ent_t                     c28, aa, skew;
  ent_t                     sk [3];
  logic signed [PRD_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc, plo, phi, rfull;
  logic signed [SKP_W-1:0]  skp;
  logic signed [TRIG_W-1:0] cr;
  mat_t                     m;

  aavr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (st == S_START),
    .angle (angle),
    .done  (tdone),
    .cs    (cs),
    .sn    (sn)
  );

  assign ica_lo = ica[LO_W-1:0];
  assign ica_hi = ica[ICA_W-1:LO_W];
  assign plo    = prod * $signed({1'b0, ica_lo});
  assign phi    = prod * ica_hi;
  assign rfull  = (acc + HALF_AA) >>> 32;
  assign skp    = axis[k] * sn;
  assign cr     = (cs + HALF_C) >>> 2;

  // Cross-product part of each entry; the diagonal takes the cosine instead
  always_comb begin
    case ({ri, ci})
      4'b0100: skew = sk[2];
      4'b0001: skew = -sk[2];
      4'b1000: skew = -sk[1];
      4'b0010: skew = sk[1];
      4'b0110: skew = -sk[0];
      4'b1001: skew = sk[0];
      default: skew = c28;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_START;
      valid <= 1'b0;
      k     <= '0;
      ri    <= '0;
      ci    <= '0;
    end else if (start) begin
      st    <= S_START;
      valid <= 1'b0;
    end else begin
      case (st)
        S_START: st <= S_TRIG;
        S_TRIG:  if (tdone) st <= S_PREP;
        S_PREP: begin
          k  <= '0;
          st <= S_SKEW;
        end
        S_SKEW: begin
          if (k == 2'd2) begin
            ri <= '0;
            ci <= '0;
            st <= S_AA;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_AA:  st <= S_LO;
        S_LO:  st <= S_HI;
        S_HI:  st <= S_RND;
        S_RND: st <= S_WR;
        S_WR: begin
          if (ci == 2'd2) begin
            ci <= '0;
            if (ri == 2'd2) begin
              valid <= 1'b1;
              st    <= S_DONE;
            end else begin
              ri <= ri + 1'b1;
              st <= S_AA;
            end
          end else begin
            ci <= ci + 1'b1;
            st <= S_AA;
          end
        end
        S_DONE:  st <= S_DONE;
        default: st <= S_START;
      endcase
    end
  end

  // a_i*a_j*(1-cos) is split over the low and high halves of (1-cos)
  always_ff @(posedge clk) begin
    case (st)
      S_PREP: begin
        ica <= ONE_Q30 - ICA_W'(cs);
        c28 <= ENT_W'(cr);
      end
      S_SKEW: sk[k] <= ENT_W'((skp + HALF_SK) >>> 17);
      S_AA:   prod <= axis[ri] * axis[ci];
      S_LO:   acc <= plo;
      S_HI:   acc <= acc + (phi <<< LO_W);
      S_RND:  aa <= ENT_W'(rfull);
      S_WR:   m[ri][ci] <= aa + skew;
      default: ;
    endcase
  end

  assign mo.valid = valid;
  assign mo.m     = m;

`ifndef ASSERT_OFF
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start |=> (st == S_START) && !valid)
    else $error("matrix still marked valid after a rebuild request");

  a_valid_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(valid) |-> $past(st == S_WR) && $past(ri == 2'd2) && $past(ci == 2'd2))
    else $error("matrix marked valid before the last entry was written");

  a_skew_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_SKEW) |-> (k != 2'd3))
    else $error("skew counter out of range");
`endif

endmodule

[hdl/aavr_lane.sv]
`timescale 1ns / 1ps

module aavr_lane import aavr_pkg::*; (
  input  logic                       clk,
  input  logic                       load,
  input  vec_t                       vec,
  input  row_t                       row,
  output logic signed [OUT_BITS-1:0] res
);

  localparam int PROD_W = SAMPLE_BITS + ENT_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RES_W  = SUM_W - FRAC;

  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((64'sd1 <<< SAMPLE_BITS) - 1);
  localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-(64'sd1 <<< SAMPLE_BITS));

  logic signed [PROD_W-1:0] prod [3];
  logic signed [SUM_W-1:0]  s0, s1, s2, sum;
  logic signed [RES_W-1:0]  rnd;

  // One product per vector component, registered
  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= vec[j] * row[j];
      end
    end
  end

  assign s0  = SUM_W'(prod[0]);
  assign s1  = SUM_W'(prod[1]);
  assign s2  = SUM_W'(prod[2]);
  assign sum = s0 + s1 + s2 + HALF;
  assign rnd = RES_W'(sum >>> FRAC);

  always_comb begin
    if (rnd > SAT_HI) begin
      res = OUT_BITS'(SAT_HI);
    end else if (rnd < SAT_LO) begin
      res = OUT_BITS'(SAT_LO);
    end else begin
      res = OUT_BITS'(rnd);
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

// Stream bench for the axis-angle vector rotator.
module tb;
  import aavr_pkg::*;

  // Result beat as it sits in m_axis_tdata: x in the low bits, then y, then z
  typedef struct packed {
    logic signed [OUT_BITS-1:0] z;
    logic signed [OUT_BITS-1:0] y;
    logic signed [OUT_BITS-1:0] x;
  } rot_vec_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_VEC} row_kind_t;

  // One directed step: a register write or a vector, with an optional
  // hand-typed result (otherwise the predictor supplies it)
  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [REG_W-1:0]           data;
    smp_t                       vx;
    smp_t                       vy;
    smp_t                       vz;
    logic                       typed;
    logic signed [OUT_BITS-1:0] ex;
    logic signed [OUT_BITS-1:0] ey;
    logic signed [OUT_BITS-1:0] ez;
  } dir_row_t;

  typedef enum int {RX_FLOW, RX_SPARSE, RX_PATTERN, RX_COIN} rx_mode_t;

  // Indexes past the register file; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 8'd7;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP    = 8'hFF;

  localparam int     VEC_TARGET   = 1850;
  localparam int     CORDIC_STEPS = (TRIG_STAGES < 24) ? TRIG_STAGES : 24;
  localparam longint TRIG_GAIN    = 64'sd652032874;
  localparam longint OUT_HI       = (longint'(1) <<< SAMPLE_BITS) - 1;
  localparam longint OUT_LO       = -(longint'(1) <<< SAMPLE_BITS);

  // Arctangent of 2^-i, one turn = 2^32
  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  localparam dir_row_t DIRECTED_PLAN [32] = '{
    // reset setting: +z axis, angle zero
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sd32767, 16'sh8000, 16'sd1, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sh8000, 16'sd32767, -16'sd1, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    // quarter turn about z
    '{ROW_CFG, REG_TURN_ANGLE, 16'd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sd32767, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sd0, 16'sh8000, 16'sd32767, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    // zero axis, angle zero: identity
    '{ROW_CFG, REG_AXIS_Z, 16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_TURN_ANGLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sd32767, 16'sh8000, 16'sd1,
      1'b1, 17'sd32767, -17'sd32768, 17'sd1},
    '{ROW_VEC, REG_AXIS_X, 16'h0, -16'sd1, 16'sd0, 16'sh8000,
      1'b1, -17'sd1, 17'sd0, -17'sd32768},
    // zero axis, half turn: plain negation, +32768 needs the extra bit
    '{ROW_CFG, REG_TURN_ANGLE, 16'd32768, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sh8000, 16'sd32767, 16'sd5,
      1'b1, 17'sd32768, -17'sd32767, -17'sd5},
    // oversized axis (-1,-1,-1) at half turn: every row saturates
    '{ROW_CFG, REG_AXIS_X, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_AXIS_Y, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_AXIS_Z, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sd32767, 16'sd32767, 16'sd32767,
      1'b1, 17'sd65535, 17'sd65535, 17'sd65535},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sh8000, 16'sh8000, 16'sh8000,
      1'b1, 17'sh10000, 17'sh10000, 17'sh10000},
    // writes past the register file are dropped
    '{ROW_CFG, IDX_UNUSED, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, IDX_TOP, 16'hAAAA, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sd1, 16'sd2, 16'sd3, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    // diagonal xz axis, largest angle
    '{ROW_CFG, REG_AXIS_X, 16'd23170, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_AXIS_Y, 16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_AXIS_Z, 16'd23170, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_TURN_ANGLE, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sd32767, 16'sd32767, 16'sh8000,
      1'b0, 17'sd0, 17'sd0, 17'sd0},
    // all-max axis, three-quarter and eighth turn
    '{ROW_CFG, REG_AXIS_X, 16'd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_AXIS_Y, 16'd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_AXIS_Z, 16'd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_TURN_ANGLE, 16'd49152, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sd12345, -16'sd23456, 16'sd30000,
      1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_CFG, REG_TURN_ANGLE, 16'd8192, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
    '{ROW_VEC, REG_AXIS_X, 16'h0, 16'sh8000, 16'sh8000, 16'sd32767,
      1'b0, 17'sd0, 17'sd0, 17'sd0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Register mirror, updated on each accepted write
  axc_t        axis_cur [3] = '{16'sd0, 16'sd0, 16'sd32767};
  logic [15:0] angle_cur = 16'd0;

  rot_vec_t want_q [$];
  int       fault_count    = 0;
  int       results_seen   = 0;
  int       vectors_sent   = 0;
  int       cfg_writes     = 0;
  int       settings_count = 0;
  int       burst_left     = 0;
  bit       offering       = 1'b0;
  int       hold_left      = 0;
  int       hold_cycles    = 0;
  bit       pressure_done  = 1'b0;
  rx_mode_t rx_mode        = RX_FLOW;
  int       mode_left      = 0;
  logic [15:0] rx_pattern  = 16'b1101_1011_0111_0010;

  axis_angle_vector_rotation u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Round half up, then shift right arithmetically
  function automatic longint half_up_shr(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Fixed-length CORDIC on the low 30 phase bits, quadrant fold after
  function automatic void trig_q30(input logic [15:0] ang, output longint cs,
                                   output longint sn);
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    logic [31:0] phase;
    phase = 32'(ang & 16'((1 << ANGLE_BITS) - 1)) << (32 - ANGLE_BITS);
    z = longint'({2'b00, phase[29:0]});
    x = TRIG_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    case (phase[31:30])
      2'd0: begin
        cs = x;
        sn = y;
      end
      2'd1: begin
        cs = -y;
        sn = x;
      end
      2'd2: begin
        cs = -x;
        sn = -y;
      end
      default: begin
        cs = y;
        sn = -x;
      end
    endcase
  endfunction

  // Rotated vector for the mirrored axis and angle
  function automatic rot_vec_t rotate_vec(input vec_t v);
    longint   a [3];
    longint   w [3];
    longint   sa [3];
    longint   m [3][3];
    longint   cs;
    longint   sn;
    longint   ica;
    longint   c28;
    longint   acc;
    logic signed [OUT_BITS-1:0] o [3];
    smp_t     comp;
    rot_vec_t r;
    trig_q30(angle_cur, cs, sn);
    ica = (longint'(1) <<< 30) - cs;
    c28 = half_up_shr(cs, 2);
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(axis_cur[i]);
      comp = v[i];
      w[i] = longint'(comp);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = half_up_shr(a[i] * a[j] * ica, 32);
      end
      m[i][i] = m[i][i] + c28;
      sa[i] = half_up_shr(a[i] * sn, 17);
    end
    // cross-product part of the matrix
    m[1][0] = m[1][0] + sa[2];
    m[0][1] = m[0][1] - sa[2];
    m[2][0] = m[2][0] - sa[1];
    m[0][2] = m[0][2] + sa[1];
    m[1][2] = m[1][2] - sa[0];
    m[2][1] = m[2][1] + sa[0];
    for (int i = 0; i < 3; i++) begin
      acc = half_up_shr(w[0] * m[i][0] + w[1] * m[i][1] + w[2] * m[i][2], 28);
      if (acc > OUT_HI) acc = OUT_HI;
      if (acc < OUT_LO) acc = OUT_LO;
      o[i] = acc[OUT_BITS-1:0];
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    return r;
  endfunction

  function automatic smp_t rand_comp(input int style);
    if (style == 0) return smp_t'($urandom_range(0, 65535));
    if (style == 1) begin
      case ($urandom_range(0, 4))
        0:       return 16'sh8000;
        1:       return 16'sd32767;
        2:       return -16'sd1;
        3:       return 16'sd0;
        default: return 16'sd1;
      endcase
    end
    return smp_t'(int'($urandom_range(0, 127)) - 64);
  endfunction

  function automatic vec_t rand_vec();
    int   style;
    vec_t v;
    style = $urandom_range(0, 19);
    style = (style < 14) ? 0 : ((style < 17) ? 1 : 2);
    for (int i = 0; i < 3; i++) v[i] = rand_comp(style);
    return v;
  endfunction

  // Offer one register write; leave cfg_valid up so back-to-back writes
  // need no extra edge. Mirror the register once the beat is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AXIS_X:     axis_cur[0] = data;
      REG_AXIS_Y:     axis_cur[1] = data;
      REG_AXIS_Z:     axis_cur[2] = data;
      REG_TURN_ANGLE: angle_cur = data;
      default:        ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  // Drop tvalid and end the current burst
  task automatic stop_stream();
    if (offering) s_axis_tvalid <= 1'b0;
    offering   = 1'b0;
    burst_left = 0;
  endtask

  // Hold until every queued result has come back
  task automatic drain();
    while (want_q.size() != 0) @(negedge clk);
  endtask

  // Send one vector beat. Between bursts, drop tvalid and idle the sender.
  task automatic send_vec(input vec_t v, input bit typed, input rot_vec_t typed_res);
    if (burst_left == 0) begin
      if (offering) s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(v);
    offering = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    want_q.insert(want_q.size(), typed ? typed_res : rotate_vec(v));
    vectors_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Pick an axis and angle, write all four registers in a rotated order, sometimes one more past them
  task automatic new_setting();
    real                  rx;
    real                  ry;
    real                  rz;
    real                  nrm;
    axc_t                 ax [3];
    logic [15:0]          ang;
    int                   first;
    logic [CFG_IDX_W-1:0] order [4];
    order = '{REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z, REG_TURN_ANGLE};
    case ($urandom_range(0, 5))
      0, 1: begin
        // near-unit axis
        rx = real'(int'($urandom_range(0, 65535)) - 32768);
        ry = real'(int'($urandom_range(0, 65535)) - 32768);
        rz = real'(int'($urandom_range(0, 65535)) - 32768);
        nrm = $sqrt(rx * rx + ry * ry + rz * rz);
        if (nrm < 1.0) begin
          rz  = 1.0;
          nrm = 1.0;
        end
        ax[0] = axc_t'($rtoi(rx / nrm * 32767.0));
        ax[1] = axc_t'($rtoi(ry / nrm * 32767.0));
        ax[2] = axc_t'($rtoi(rz / nrm * 32767.0));
      end
      2: begin
        ax = '{16'sd0, 16'sd0, 16'sd0};
        ax[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'sd32767 : 16'sh8000;
      end
      3: begin
        // arbitrary length: saturation is likely
        for (int i = 0; i < 3; i++) ax[i] = axc_t'($urandom_range(0, 65535));
      end
      4: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 2))
            0:       ax[i] = 16'sh8000;
            1:       ax[i] = 16'sd32767;
            default: ax[i] = 16'sd0;
          endcase
        end
      end
      default: ax = '{16'sd0, 16'sd0, 16'sd0};
    endcase
    case ($urandom_range(0, 15))
      0:       ang = 16'd0;
      1:       ang = 16'd1;
      2:       ang = 16'd16384;
      3:       ang = 16'd32768;
      4:       ang = 16'd49152;
      5:       ang = 16'hFFFF;
      6:       ang = 16'd8192;
      7:       ang = 16'd24576;
      default: ang = 16'($urandom_range(0, 65535));
    endcase
    first = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      case (order[(k + first) % 4])
        REG_AXIS_X: write_reg(REG_AXIS_X, ax[0]);
        REG_AXIS_Y: write_reg(REG_AXIS_Y, ax[1]);
        REG_AXIS_Z: write_reg(REG_AXIS_Z, ax[2]);
        default:    write_reg(REG_TURN_ANGLE, ang);
      endcase
    end
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_IDX_W'($urandom_range(NREG, 255)), REG_W'($urandom_range(0, 65535)));
    settings_count++;
  endtask

  task automatic check_field(input string name, input logic signed [OUT_BITS-1:0] want,
                             input logic signed [OUT_BITS-1:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d",
                 results_seen, name, want, got);
    end
  endtask

  // Receiver: switch between stall modes at random. Once,
  // while the sender is busy, hold off long enough to back up the pipe.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!pressure_done && results_seen >= 400 && offering) begin
      pressure_done = 1'b1;
      hold_left     = 299;
      hold_cycles   = 300;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 160);
      end
      mode_left--;
      rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
      case (rx_mode)
        RX_FLOW:    m_axis_tready <= 1'b1;
        RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: m_axis_tready <= rx_pattern[0];
        default:    m_axis_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Output monitor: compare each taken beat with the oldest prediction
  always @(posedge clk) begin
    rot_vec_t got;
    rot_vec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[3*OUT_BITS-1:0];
      if (want_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result beat: x %0d y %0d z %0d", got.x, got.y, got.z);
      end else begin
        want = want_q.pop_front();
        check_field("out_x", want.x, got.x);
        check_field("out_y", want.y, got.y);
        check_field("out_z", want.z, got.z);
        check_field("pad", '0, OUT_BITS'(m_axis_tdata[OUT_DATA_W-1:3*OUT_BITS]));
      end
      results_seen++;
    end
  end

  initial begin
    dir_row_t row;
    vec_t     v;
    rot_vec_t res;
    bit       in_cfg;
    int       directed_vecs;
    int       phase_len;
    in_cfg = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pass: extremes, identity, negation, saturation, dropped writes
    for (int r = 0; r < $size(DIRECTED_PLAN); r++) begin
      row = DIRECTED_PLAN[r];
      if (row.kind == ROW_CFG) begin
        if (!in_cfg) begin
          stop_stream();
          drain();
          in_cfg = 1'b1;
        end
        write_reg(row.idx, row.data);
      end else begin
        if (in_cfg) begin
          cfg_valid <= 1'b0;
          in_cfg = 1'b0;
        end
        v[0] = row.vx;
        v[1] = row.vy;
        v[2] = row.vz;
        res.x = row.ex;
        res.y = row.ey;
        res.z = row.ez;
        send_vec(v, row.typed, res);
      end
    end
    directed_vecs = vectors_sent;

    // Random phases: idle the stream, change the setting, then stream vectors
    while (vectors_sent < VEC_TARGET) begin
      stop_stream();
      drain();
      new_setting();
      cfg_valid <= 1'b0;
      phase_len = $urandom_range(20, 160);
      for (int n = 0; n < phase_len && vectors_sent < VEC_TARGET; n++)
        send_vec(rand_vec(), 1'b0, res);
    end

    stop_stream();
    drain();
    repeat (10) @(posedge clk);

    if (want_q.size() != 0) begin
      fault_count += want_q.size();
      $display("%0d predicted results never arrived", want_q.size());
    end
    $display("covered %0d vectors (%0d directed) over %0d random settings, %0d writes",
             vectors_sent, directed_vecs, settings_count, cfg_writes);
    $display("checked %0d result beats, one output hold of %0d cycles, %0d mismatches",
             results_seen, hold_cycles, fault_count);
    if (fault_count == 0) begin
      $display("[axis_angle_vector_rotation] OK");
    end else begin
      $display("[axis_angle_vector_rotation] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("timeout after %0d results", results_seen);
    $display("[axis_angle_vector_rotation] ERROR");
    $finish;
  end

endmodule
